// ----- design/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off during reset.
`define CRT_ASSERT_IMPL(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("same-cycle implication failed");

// Next-cycle implication, switched off during reset.
`define CRT_ASSERT_NEXT(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("next-cycle implication failed");

`endif

// ----- design/crt_pkg.sv -----
// Package for the reference-count table: defaults, status codes, chain control struct.
package crt_pkg;

  localparam int TABLE_ENTRIES_DEF = 64;
  localparam int REF_BITS_DEF      = 8;
  localparam int PAGE_W            = 19;
  localparam int STATUS_W          = 3;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED    = 3'd0,
    ST_INCREMENTED = 3'd1,
    ST_FULL        = 3'd2,
    ST_UNTRACKED   = 3'd3,
    ST_LAST        = 3'd4,
    ST_DECREMENTED = 3'd5,
    ST_UNDERFLOW   = 3'd6
  } status_t;

  // Control part of the request token as it walks the chain
  typedef struct packed {
    logic    act;     // token present in this stage
    logic    rel;     // release request (else share)
    logic    hit;     // a cell has matched the page
    logic    fre;     // a free cell has been found
    status_t status;  // outcome set by the matching cell
  } tok_ctl_t;

endpackage

// ----- design/crt_cell.sv -----
// One table entry of the chain: holds valid, page and count, serves the passing token.
module crt_cell import crt_pkg::*; #(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int REF_BITS      = REF_BITS_DEF,
  parameter int CELL_INDEX    = 0
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             adv,
  input  tok_ctl_t                         ctl_in,
  input  logic [PAGE_W-1:0]                page_in,
  input  logic [$clog2(TABLE_ENTRIES)-1:0] idx_in,
  input  logic [REF_BITS-1:0]              cnt_in,
  output tok_ctl_t                         ctl_out,
  output logic [PAGE_W-1:0]                page_out,
  output logic [$clog2(TABLE_ENTRIES)-1:0] idx_out,
  output logic [REF_BITS-1:0]              cnt_out,
  input  logic                             wr_en,
  input  logic [$clog2(TABLE_ENTRIES)-1:0] wr_idx,
  input  logic [PAGE_W-1:0]                wr_page
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam logic [IDX_W-1:0]    MY_IDX    = IDX_W'(CELL_INDEX);
  localparam logic [REF_BITS-1:0] REF_MAX   = {REF_BITS{1'b1}};
  localparam logic [REF_BITS-1:0] REF_ONE   = REF_BITS'(1);
  localparam logic [REF_BITS-1:0] NEW_SHARE = REF_BITS'(2);

  logic                valid, valid_next;
  logic [PAGE_W-1:0]   page, page_next;
  logic [REF_BITS-1:0] refs, refs_next;

  tok_ctl_t            ctl_next;
  logic [IDX_W-1:0]    idx_next;
  logic [REF_BITS-1:0] cnt_next;

  logic match, take_free;

  // Entry update and token update
  always_comb begin
    match     = ctl_in.act && valid && (page == page_in) && !ctl_in.hit;
    take_free = ctl_in.act && !valid && !ctl_in.hit && !ctl_in.fre;
    ctl_next   = ctl_in;
    idx_next   = idx_in;
    cnt_next   = cnt_in;
    valid_next = valid;
    page_next  = page;
    refs_next  = refs;
    if (match) begin
      ctl_next.hit = 1'b1;
      idx_next     = MY_IDX;
      if (!ctl_in.rel) begin
        // share: saturating increment
        if (refs != REF_MAX) begin
          refs_next = refs + REF_ONE;
        end
        ctl_next.status = ST_INCREMENTED;
        cnt_next        = refs_next;
      end else if (refs == REF_ONE) begin
        // last reference frees the entry
        valid_next      = 1'b0;
        page_next       = '0;
        refs_next       = '0;
        ctl_next.status = ST_LAST;
        cnt_next        = '0;
      end else if (refs != '0) begin
        refs_next       = refs - REF_ONE;
        ctl_next.status = ST_DECREMENTED;
        cnt_next        = refs_next;
      end else begin
        ctl_next.status = ST_UNDERFLOW;
        cnt_next        = '0;
      end
    end else if (take_free) begin
      ctl_next.fre = 1'b1;
      idx_next     = MY_IDX;
    end
    // allocation write from the tail after a share miss
    if (wr_en && (wr_idx == MY_IDX)) begin
      valid_next = 1'b1;
      page_next  = wr_page;
      refs_next  = NEW_SHARE;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= 1'b0;
      ctl_out <= '0;
    end else if (adv) begin
      valid   <= valid_next;
      ctl_out <= ctl_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (adv) begin
      page     <= page_next;
      refs     <= refs_next;
      page_out <= page_in;
      idx_out  <= idx_next;
      cnt_out  <= cnt_next;
    end
  end

endmodule

// ----- design/cow_page_refcount_table.sv -----
// Top level of the copy-on-write page reference-count table: cell chain and result stage.
//
//  channel | beat fields                                  | handshake
//  --------+----------------------------------------------+---------------------
//  in      | req_type, page_number                        | in_valid / in_stall
//  out     | status, free_frame, ref_count, entry_index   | out_valid / out_stall
//
// A request walks the chain one cell per cycle unless an output stall holds the chain; the
// result is registered from the tail token, and the next request is taken only once that
// token has left the chain, so one request is in the chain at a time.
// A share miss writes the lowest free cell from the tail as the result is loaded.
// Reset clears all valid bits at once; the table is ready the cycle after reset.
// An output stall holds the tail token; the next request is taken once the token leaves.
module cow_page_refcount_table import crt_pkg::*; #(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int REF_BITS      = REF_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             req_type,
  input  logic [PAGE_W-1:0]                page_number,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [STATUS_W-1:0]              status,
  output logic                             free_frame,
  output logic [REF_BITS-1:0]              ref_count,
  output logic [$clog2(TABLE_ENTRIES)-1:0] entry_index
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam logic [REF_BITS-1:0] NEW_SHARE = REF_BITS'(2);

  tok_ctl_t            ctl  [0:TABLE_ENTRIES];
  logic [PAGE_W-1:0]   pg   [0:TABLE_ENTRIES];
  logic [IDX_W-1:0]    idx  [0:TABLE_ENTRIES];
  logic [REF_BITS-1:0] cnt  [0:TABLE_ENTRIES];

  logic inflight, adv, leave, alloc;
  tok_ctl_t tail;

  status_t             res_status;
  logic                res_free;
  logic [REF_BITS-1:0] res_cnt;
  logic [IDX_W-1:0]    res_idx;

  assign in_stall = inflight;

  // Token entering the head cell
  always_comb begin
    ctl[0]        = '0;
    ctl[0].act    = in_valid && !inflight;
    ctl[0].rel    = req_type;
    ctl[0].status = ST_INSERTED;
  end
  assign pg[0]  = page_number;
  assign idx[0] = '0;
  assign cnt[0] = '0;

  // Chain hold while a finished token waits on a full output register
  assign tail  = ctl[TABLE_ENTRIES];
  assign adv   = !(tail.act && out_valid && out_stall);
  assign leave = tail.act && adv;
  assign alloc = leave && !tail.hit && !tail.rel && tail.fre;

  genvar k;
  generate
    for (k = 0; k < TABLE_ENTRIES; k++) begin : g_cell
      crt_cell #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .REF_BITS      (REF_BITS),
        .CELL_INDEX    (k)
      ) u_cell (
        .clk      (clk),
        .rst      (rst),
        .adv      (adv),
        .ctl_in   (ctl[k]),
        .page_in  (pg[k]),
        .idx_in   (idx[k]),
        .cnt_in   (cnt[k]),
        .ctl_out  (ctl[k+1]),
        .page_out (pg[k+1]),
        .idx_out  (idx[k+1]),
        .cnt_out  (cnt[k+1]),
        .wr_en    (alloc),
        .wr_idx   (idx[TABLE_ENTRIES]),
        .wr_page  (pg[TABLE_ENTRIES])
      );
    end
  endgenerate

  // Result of the token at the tail
  always_comb begin
    res_status = tail.status;
    res_free   = 1'b0;
    res_cnt    = cnt[TABLE_ENTRIES];
    res_idx    = idx[TABLE_ENTRIES];
    if (tail.hit) begin
      res_free = (tail.status == ST_LAST);
    end else if (!tail.rel) begin
      if (tail.fre) begin
        res_status = ST_INSERTED;
        res_cnt    = NEW_SHARE;
      end else begin
        res_status = ST_FULL;
        res_cnt    = '0;
        res_idx    = '0;
      end
    end else begin
      res_status = ST_UNTRACKED;
      res_free   = 1'b1;
      res_cnt    = '0;
      res_idx    = '0;
    end
  end

  // Busy flag and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      inflight  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (ctl[0].act) begin
        inflight <= 1'b1;
      end else if (leave) begin
        inflight <= 1'b0;
      end
      if (leave) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (leave) begin
      status      <= res_status;
      free_frame  <= res_free;
      ref_count   <= res_cnt;
      entry_index <= res_idx;
    end
  end

endmodule

// ----- design/crt_checker.sv -----
// Port-level checker for the reference-count table, with its bind.
`include "assert_macros.svh"

module crt_checker import crt_pkg::*; #(
  parameter int REF_BITS = REF_BITS_DEF,
  parameter int IDX_W    = 6
) (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input logic [STATUS_W-1:0] status,
  input logic                free_frame,
  input logic [REF_BITS-1:0] ref_count,
  input logic [IDX_W-1:0]    entry_index
);

  logic ff_due, no_entry_due, entry_clear;

  // outcomes that free the frame, and outcomes that name no entry
  assign ff_due       = (status == ST_UNTRACKED) || (status == ST_LAST);
  assign no_entry_due = (status == ST_FULL) || (status == ST_UNTRACKED);
  assign entry_clear  = (ref_count == '0) && (entry_index == '0);

  // a held result keeps its status
  `CRT_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(status))

  // one request at a time
  `CRT_ASSERT_NEXT(a_one_beat, clk, rst, in_valid && !in_stall, in_stall)

  // free_frame only for untracked or last reference
  `CRT_ASSERT_IMPL(a_free_frame, clk, rst, out_valid, free_frame == ff_due)

  // no entry for full or untracked outcomes
  `CRT_ASSERT_IMPL(a_no_entry, clk, rst, out_valid && no_entry_due, entry_clear)

endmodule

bind cow_page_refcount_table crt_checker #(
  .REF_BITS (REF_BITS),
  .IDX_W    ($clog2(TABLE_ENTRIES))
) u_crt_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .status      (status),
  .free_frame  (free_frame),
  .ref_count   (ref_count),
  .entry_index (entry_index)
);
